FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; take it in with `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CHK_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: same cycle");

// antecedent implies consequent in the next cycle
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: next cycle");

`endif

FILE: design/ustlru_pkg.sv
// Shared constants and types for the user slot table.
// No dependencies.
package ustlru_pkg;

    localparam int SLOTS      = 64;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int SLOT_OUT_W = 6;
    localparam int USER_W     = 16;
    localparam int TIME_W     = 32;
    localparam int ACT_W      = 2;

    localparam logic [ACT_W-1:0] ACT_FIND    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;

    typedef struct packed {
        logic [USER_W-1:0] user;
        logic [TIME_W-1:0] last_use;
    } entry_t;

endpackage

FILE: design/ustlru_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
module ustlru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/user_slot_table_lru_top.sv
// User slot table with LRU replacement: top level and sequencer.
// Depends on ustlru_pkg and ustlru_ram.
//
//  channel | signals                                    | accepted when
//  --------+--------------------------------------------+---------------------
//  in      | action is_system user_id now               | in_valid & in_ready
//  out     | hit slot evicted evicted_user              | out_valid & out_ready
//
// System, release and unused actions go from IDLE straight to OUT. A user find
// tries its hint slot in HINT first and goes to OUT on a hit. Otherwise, and for
// a user load, the entry RAM is scanned one slot per cycle over its single read
// port. in_ready is high only while the sequencer is idle.
// Reset clears the valid bits, hint and handshake state at once; no clearing pass.
// A stalled output holds its result; the next transaction may be accepted meanwhile.
module user_slot_table_lru_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ustlru_pkg::ACT_W-1:0]        action,
    input  logic                                is_system,
    input  logic [ustlru_pkg::USER_W-1:0]       user_id,
    input  logic [ustlru_pkg::TIME_W-1:0]       now,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic [ustlru_pkg::SLOT_OUT_W-1:0]   slot,
    output logic                                evicted,
    output logic [ustlru_pkg::USER_W-1:0]       evicted_user
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HINT = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam logic [ustlru_pkg::SLOT_W-1:0] LAST_SLOT  =
        ustlru_pkg::SLOT_W'(ustlru_pkg::SLOTS - 1);
    localparam logic [ustlru_pkg::SLOT_W-1:0] FIRST_USER = ustlru_pkg::SLOT_W'(1);
    localparam logic [ustlru_pkg::SLOT_W-1:0] SYS_SLOT   = '0;

    logic [1:0]                         state_reg, state_next;
    logic [ustlru_pkg::SLOTS-1:0]       valid_reg, valid_next;
    logic [ustlru_pkg::SLOT_W-1:0]      hint_reg, hint_next;
    logic [ustlru_pkg::USER_W-1:0]      uid_reg, uid_next;
    logic [ustlru_pkg::TIME_W-1:0]      now_reg, now_next;
    logic                               load_reg, load_next;
    logic [ustlru_pkg::SLOT_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                               issue_more_reg, issue_more_next;
    logic [ustlru_pkg::SLOT_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                               cmp_vld_reg, cmp_vld_next;
    logic [ustlru_pkg::TIME_W-1:0]      best_time_reg, best_time_next;
    logic [ustlru_pkg::SLOT_W-1:0]      best_idx_reg, best_idx_next;
    logic [ustlru_pkg::USER_W-1:0]      best_user_reg, best_user_next;
    logic                               res_hit_reg, res_hit_next;
    logic [ustlru_pkg::SLOT_W-1:0]      res_slot_reg, res_slot_next;
    logic                               res_ev_reg, res_ev_next;
    logic [ustlru_pkg::USER_W-1:0]      res_ev_user_reg, res_ev_user_next;
    logic                               out_valid_reg, out_valid_next;
    logic                               out_hit_reg, out_hit_next;
    logic [ustlru_pkg::SLOT_OUT_W-1:0]  out_slot_reg, out_slot_next;
    logic                               out_ev_reg, out_ev_next;
    logic [ustlru_pkg::USER_W-1:0]      out_ev_user_reg, out_ev_user_next;

    logic                               ram_we;
    logic [ustlru_pkg::SLOT_W-1:0]      ram_waddr;
    ustlru_pkg::entry_t                 ram_wdata;
    logic [ustlru_pkg::SLOT_W-1:0]      ram_raddr;
    ustlru_pkg::entry_t                 ram_rdata;

    logic                               accept;
    logic                               cur_valid;
    logic                               find_match;
    logic                               last_cmp;
    logic                               take_cur;
    logic [ustlru_pkg::TIME_W-1:0]      cand_time;
    logic [ustlru_pkg::SLOT_W-1:0]      cand_idx;
    logic [ustlru_pkg::USER_W-1:0]      cand_user;

    ustlru_ram #(
        .WIDTH ($bits(ustlru_pkg::entry_t)),
        .DEPTH (ustlru_pkg::SLOTS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    assign cur_valid  = valid_reg[cmp_idx_reg];
    assign find_match = cmp_vld_reg && cur_valid && (ram_rdata.user == uid_reg);
    assign last_cmp   = cmp_vld_reg && (cmp_idx_reg == LAST_SLOT);
    assign take_cur   = (cmp_idx_reg == FIRST_USER) || (ram_rdata.last_use < best_time_reg);
    assign cand_time  = take_cur ? ram_rdata.last_use : best_time_reg;
    assign cand_idx   = take_cur ? cmp_idx_reg : best_idx_reg;
    assign cand_user  = take_cur ? ram_rdata.user : best_user_reg;

    always_comb
    begin
        state_next       = state_reg;
        valid_next       = valid_reg;
        hint_next        = hint_reg;
        uid_next         = uid_reg;
        now_next         = now_reg;
        load_next        = load_reg;
        scan_idx_next    = scan_idx_reg;
        issue_more_next  = issue_more_reg;
        cmp_idx_next     = cmp_idx_reg;
        cmp_vld_next     = cmp_vld_reg;
        best_time_next   = best_time_reg;
        best_idx_next    = best_idx_reg;
        best_user_next   = best_user_reg;
        res_hit_next     = res_hit_reg;
        res_slot_next    = res_slot_reg;
        res_ev_next      = res_ev_reg;
        res_ev_user_next = res_ev_user_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_hit_next     = out_hit_reg;
        out_slot_next    = out_slot_reg;
        out_ev_next      = out_ev_reg;
        out_ev_user_next = out_ev_user_reg;

        ram_we         = 1'b0;
        ram_waddr      = cmp_idx_reg;
        ram_wdata.user = uid_reg;
        ram_wdata.last_use = now_reg;
        ram_raddr      = scan_idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = hint_reg;
                if (accept)
                begin
                    uid_next         = user_id;
                    now_next         = now;
                    load_next        = (action == ustlru_pkg::ACT_LOAD);
                    res_hit_next     = 1'b0;
                    res_slot_next    = SYS_SLOT;
                    res_ev_next      = 1'b0;
                    res_ev_user_next = '0;
                    scan_idx_next    = FIRST_USER;
                    issue_more_next  = 1'b1;
                    cmp_vld_next     = 1'b0;
                    state_next       = ST_OUT;
                    ram_waddr          = SYS_SLOT;
                    ram_wdata.user     = '0;
                    ram_wdata.last_use = now;
                    unique case (action)
                        ustlru_pkg::ACT_FIND:
                        begin
                            if (is_system)
                            begin
                                if (valid_reg[0])
                                begin
                                    ram_we       = 1'b1;
                                    res_hit_next = 1'b1;
                                end
                            end
                            else
                            begin
                                state_next = ST_HINT;
                            end
                        end
                        ustlru_pkg::ACT_LOAD:
                        begin
                            if (is_system)
                            begin
                                ram_we        = 1'b1;
                                valid_next[0] = 1'b1;
                                res_hit_next  = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        ustlru_pkg::ACT_RELEASE:
                        begin
                            valid_next = {{(ustlru_pkg::SLOTS-1){1'b0}}, valid_reg[0]};
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_HINT:
            begin
                if ((hint_reg != SYS_SLOT) && valid_reg[hint_reg] &&
                    (ram_rdata.user == uid_reg))
                begin
                    ram_we        = 1'b1;
                    ram_waddr     = hint_reg;
                    res_hit_next  = 1'b1;
                    res_slot_next = hint_reg;
                    state_next    = ST_OUT;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                logic finish;
                finish = 1'b0;
                if (!load_reg)
                begin
                    if (find_match)
                    begin
                        ram_we        = 1'b1;
                        hint_next     = cmp_idx_reg;
                        res_hit_next  = 1'b1;
                        res_slot_next = cmp_idx_reg;
                        finish        = 1'b1;
                    end
                    else if (last_cmp)
                    begin
                        finish = 1'b1;
                    end
                end
                else if (cmp_vld_reg)
                begin
                    if (!cur_valid)
                    begin
                        ram_we        = 1'b1;
                        valid_next[cmp_idx_reg] = 1'b1;
                        hint_next     = cmp_idx_reg;
                        res_hit_next  = 1'b1;
                        res_slot_next = cmp_idx_reg;
                        finish        = 1'b1;
                    end
                    else
                    begin
                        best_time_next = cand_time;
                        best_idx_next  = cand_idx;
                        best_user_next = cand_user;
                        if (last_cmp)
                        begin
                            ram_we           = 1'b1;
                            ram_waddr        = cand_idx;
                            valid_next[cand_idx] = 1'b1;
                            hint_next        = cand_idx;
                            res_hit_next     = 1'b1;
                            res_slot_next    = cand_idx;
                            res_ev_next      = 1'b1;
                            res_ev_user_next = cand_user;
                            finish           = 1'b1;
                        end
                    end
                end
                if (finish)
                begin
                    state_next = ST_OUT;
                end
                else if (issue_more_reg)
                begin
                    cmp_idx_next    = scan_idx_reg;
                    cmp_vld_next    = 1'b1;
                    scan_idx_next   = scan_idx_reg + FIRST_USER;
                    issue_more_next = (scan_idx_reg != LAST_SLOT);
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_hit_next     = res_hit_reg;
                    out_slot_next    = ustlru_pkg::SLOT_OUT_W'(res_slot_reg);
                    out_ev_next      = res_ev_reg;
                    out_ev_user_next = res_ev_user_reg;
                    state_next       = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            hint_reg       <= '0;
            issue_more_reg <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            hint_reg       <= hint_next;
            issue_more_reg <= issue_more_next;
            cmp_vld_reg    <= cmp_vld_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        uid_reg         <= uid_next;
        now_reg         <= now_next;
        load_reg        <= load_next;
        scan_idx_reg    <= scan_idx_next;
        cmp_idx_reg     <= cmp_idx_next;
        best_time_reg   <= best_time_next;
        best_idx_reg    <= best_idx_next;
        best_user_reg   <= best_user_next;
        res_hit_reg     <= res_hit_next;
        res_slot_reg    <= res_slot_next;
        res_ev_reg      <= res_ev_next;
        res_ev_user_reg <= res_ev_user_next;
        out_hit_reg     <= out_hit_next;
        out_slot_reg    <= out_slot_next;
        out_ev_reg      <= out_ev_next;
        out_ev_user_reg <= out_ev_user_next;
    end

    assign out_valid    = out_valid_reg;
    assign hit          = out_hit_reg;
    assign slot         = out_slot_reg;
    assign evicted      = out_ev_reg;
    assign evicted_user = out_ev_user_reg;

endmodule

FILE: design/ustlru_checker.sv
// Port-level checks for the user slot table, bound to the top level.
// Depends on ustlru_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ustlru_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic                               hit,
    input logic [ustlru_pkg::SLOT_OUT_W-1:0]  slot,
    input logic                               evicted,
    input logic [ustlru_pkg::USER_W-1:0]      evicted_user
);

    logic                                                 res_zero;
    logic [ustlru_pkg::SLOT_OUT_W+ustlru_pkg::USER_W+1:0] res_bits;

    assign res_zero = (slot == '0) && !evicted && (evicted_user == '0);
    assign res_bits = {hit, slot, evicted, evicted_user};

    // in_ready is low in the cycle after each accepted request
    `CHK_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    // a miss reports all zero fields
    `CHK_SAME(a_miss_zero, clk, rst_n, out_valid && !hit, res_zero)
    // an eviction only comes from a completed user load
    `CHK_SAME(a_evict_user, clk, rst_n, out_valid && evicted, hit && (slot != '0))
    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `CHK_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(res_bits))

endmodule

bind user_slot_table_lru_top ustlru_checker u_ustlru_checker (.*);

FILE: sim/tb_top.sv
// Testbench for user_slot_table_lru_top: directed and random table requests,
// a local slot table predictor, and field-by-field result checks.
// Depends on ustlru_pkg and the design files.
`timescale 1ns / 100ps

module tb_top;

    localparam int SLOTS      = ustlru_pkg::SLOTS;
    localparam int SLOT_OUT_W = ustlru_pkg::SLOT_OUT_W;
    localparam int USER_W     = ustlru_pkg::USER_W;
    localparam int TIME_W     = ustlru_pkg::TIME_W;
    localparam int ACT_W      = ustlru_pkg::ACT_W;

    localparam logic [ACT_W-1:0] ACT_FIND    = ustlru_pkg::ACT_FIND;
    localparam logic [ACT_W-1:0] ACT_LOAD    = ustlru_pkg::ACT_LOAD;
    localparam logic [ACT_W-1:0] ACT_RELEASE = ustlru_pkg::ACT_RELEASE;
    localparam logic [ACT_W-1:0] ACT_UNUSED  = 2'd3;
    localparam int POOL_SIZE    = 80;
    localparam int RANDOM_ITEMS = 800;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 2 * SLOTS + 16;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic              is_system;
        logic [USER_W-1:0] user_id;
        logic [TIME_W-1:0] now;
    } req_t;

    typedef struct packed {
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  evicted;
        logic [USER_W-1:0]     evicted_user;
    } lookup_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [ACT_W-1:0]      action;
    logic                  is_system;
    logic [USER_W-1:0]     user_id;
    logic [TIME_W-1:0]     now;
    logic                  out_valid;
    logic                  out_ready;
    logic                  hit;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  evicted;
    logic [USER_W-1:0]     evicted_user;

    // predictor copy of the table
    logic              tbl_valid [SLOTS];
    logic [USER_W-1:0] tbl_user  [SLOTS];
    logic [TIME_W-1:0] tbl_stamp [SLOTS];
    int                tbl_hint;

    req_t    req_backlog [$];
    lookup_t want_results [$];
    req_t    cur_req;
    lookup_t want;
    int      n_sent;
    int      n_total;
    int      err_count;
    int      hold_left;
    logic    hold_armed;

    logic [USER_W-1:0] user_pool [POOL_SIZE];
    logic [TIME_W-1:0] time_base;

    user_slot_table_lru_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .is_system    (is_system),
        .user_id      (user_id),
        .now          (now),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hit          (hit),
        .slot         (slot),
        .evicted      (evicted),
        .evicted_user (evicted_user)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic lookup_t table_predict(req_t rq);
        lookup_t r;
        int      i;
        int      pick;
        bit      found;
        r = '0;
        found = 1'b0;
        pick = 0;
        unique case (rq.action)
            ACT_FIND:
            begin
                if (rq.is_system)
                begin
                    if (tbl_valid[0])
                    begin
                        tbl_stamp[0] = rq.now;
                        r.hit = 1'b1;
                    end
                end
                else if (tbl_hint > 0 && tbl_valid[tbl_hint] && tbl_user[tbl_hint] == rq.user_id)
                begin
                    tbl_stamp[tbl_hint] = rq.now;
                    r.hit = 1'b1;
                    r.slot = SLOT_OUT_W'(tbl_hint);
                end
                else
                begin
                    for (i = 1; i < SLOTS; i++)
                    begin
                        if (!found && tbl_valid[i] && tbl_user[i] == rq.user_id)
                        begin
                            found = 1'b1;
                            tbl_hint = i;
                            tbl_stamp[i] = rq.now;
                            r.hit = 1'b1;
                            r.slot = SLOT_OUT_W'(i);
                        end
                    end
                end
            end
            ACT_LOAD:
            begin
                if (rq.is_system)
                begin
                    tbl_valid[0] = 1'b1;
                    tbl_user[0] = '0;
                    tbl_stamp[0] = rq.now;
                    r.hit = 1'b1;
                end
                else
                begin
                    for (i = 1; i < SLOTS; i++)
                    begin
                        if (!found && !tbl_valid[i])
                        begin
                            pick = i;
                            found = 1'b1;
                        end
                    end
                    if (!found)
                    begin
                        pick = 1;
                        for (i = 2; i < SLOTS; i++)
                            if (tbl_stamp[i] < tbl_stamp[pick])
                                pick = i;
                        r.evicted = 1'b1;
                        r.evicted_user = tbl_user[pick];
                    end
                    tbl_valid[pick] = 1'b1;
                    tbl_user[pick] = rq.user_id;
                    tbl_stamp[pick] = rq.now;
                    tbl_hint = pick;
                    r.hit = 1'b1;
                    r.slot = SLOT_OUT_W'(pick);
                end
            end
            ACT_RELEASE:
            begin
                for (i = 1; i < SLOTS; i++)
                    tbl_valid[i] = 1'b0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic int cur_phase();
        return (n_sent * 4) / ((n_total > 0) ? n_total : 1);
    endfunction

    function automatic bit sender_idles();
        unique case (cur_phase())
            1:       return $urandom_range(99) < 74;
            3:       return $urandom_range(99) < 22;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        unique case (cur_phase())
            2:       return $urandom_range(99) < 74;
            3:       return $urandom_range(99) < 22;
            default: return 1'b0;
        endcase
    endfunction

    task automatic push_req(logic [ACT_W-1:0] act, logic sys, logic [USER_W-1:0] uid,
                            logic [TIME_W-1:0] tm);
        req_t rq;
        rq.action = act;
        rq.is_system = sys;
        rq.user_id = uid;
        rq.now = tm;
        req_backlog.push_back(rq);
    endtask

    function automatic logic [TIME_W-1:0] next_time();
        int k;
        k = $urandom_range(99);
        if (k < 94)
        begin
            time_base = time_base + TIME_W'($urandom_range(0, 3));
            return time_base;
        end
        else if (k < 97)
            return $urandom;
        else if (k < 98)
            return '0;
        else if (k < 99)
            return '1;
        time_base = $urandom;
        return time_base;
    endfunction

    task automatic add_random(int count);
        int                n;
        int                r;
        logic [USER_W-1:0] uid;
        for (n = 0; n < count; n++)
        begin
            r = $urandom_range(999);
            uid = ($urandom_range(99) < 75) ? user_pool[$urandom_range(POOL_SIZE - 1)]
                                            : USER_W'($urandom);
            if (r < 420)
                push_req(ACT_LOAD, 1'b0, user_pool[$urandom_range(POOL_SIZE - 1)], next_time());
            else if (r < 840)
                push_req(ACT_FIND, 1'b0, uid, next_time());
            else if (r < 890)
                push_req(ACT_FIND, 1'b1, uid, next_time());
            else if (r < 930)
                push_req(ACT_LOAD, 1'b1, uid, next_time());
            else if (r < 935)
                push_req(ACT_RELEASE, 1'($urandom_range(1)), uid, next_time());
            else if (r < 965)
                push_req(ACT_UNUSED, 1'($urandom_range(1)), uid, next_time());
            else
                push_req(ACT_W'($urandom_range(3)), 1'($urandom_range(1)), USER_W'($urandom),
                         $urandom);
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            action    <= ACT_FIND;
            is_system <= 1'b0;
            user_id   <= '0;
            now       <= '0;
            n_sent    <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                want_results.push_back(table_predict(cur_req));
                n_sent <= n_sent + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (req_backlog.size() != 0 && !sender_idles())
                begin
                    cur_req = req_backlog.pop_front();
                    in_valid  <= 1'b1;
                    action    <= cur_req.action;
                    is_system <= cur_req.is_system;
                    user_id   <= cur_req.user_id;
                    now       <= cur_req.now;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off once, early in the unthrottled phase
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end
        else if (hold_armed && n_total > 0 && n_sent >= n_total / 8)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (want_results.size() == 0)
                begin
                    $error("result transaction with none expected");
                    err_count++;
                end
                else
                begin
                    want = want_results.pop_front();
                    if (hit !== want.hit)
                    begin
                        $error("hit: expected %0d, actual %0d", want.hit, hit);
                        err_count++;
                    end
                    if (slot !== want.slot)
                    begin
                        $error("slot: expected %0d, actual %0d", want.slot, slot);
                        err_count++;
                    end
                    if (evicted !== want.evicted)
                    begin
                        $error("evicted: expected %0d, actual %0d", want.evicted, evicted);
                        err_count++;
                    end
                    if (evicted_user !== want.evicted_user)
                    begin
                        $error("evicted_user: expected %h, actual %h",
                               want.evicted_user, evicted_user);
                        err_count++;
                    end
                end
            end
            out_ready <= (hold_left == 0) && !receiver_stalls();
        end
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int i;
        rst_n = 1'b0;
        err_count = 0;
        n_total = 0;
        tbl_hint = 0;
        for (i = 0; i < SLOTS; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_user[i]  = '0;
            tbl_stamp[i] = '0;
        end
        for (i = 0; i < POOL_SIZE; i++)
            user_pool[i] = USER_W'($urandom);
        user_pool[0] = '0;
        user_pool[1] = '1;
        time_base = 32'd100;

        push_req(ACT_RELEASE, 1'b0, 16'h0000, 32'd0);
        push_req(ACT_UNUSED,  1'b0, 16'h0000, 32'd0);
        push_req(ACT_FIND,    1'b1, 16'h0000, 32'd1);
        push_req(ACT_FIND,    1'b0, 16'h1234, 32'd2);
        push_req(ACT_LOAD,    1'b1, 16'h0000, 32'd0);
        push_req(ACT_FIND,    1'b1, 16'h0000, 32'hFFFF_FFFF);
        push_req(ACT_LOAD,    1'b0, 16'h0000, 32'd10);
        push_req(ACT_LOAD,    1'b0, 16'hFFFF, 32'd11);
        push_req(ACT_LOAD,    1'b0, 16'h1234, 32'd12);
        push_req(ACT_FIND,    1'b0, 16'h0000, 32'd13);   // hint stale, scan
        push_req(ACT_FIND,    1'b0, 16'h0000, 32'd14);   // hint hit
        push_req(ACT_LOAD,    1'b0, 16'h1234, 32'd15);   // duplicate id
        push_req(ACT_FIND,    1'b0, 16'h1234, 32'd16);
        push_req(ACT_FIND,    1'b0, 16'hFFFF, 32'd17);
        push_req(ACT_FIND,    1'b0, 16'h1234, 32'd18);   // first match wins
        push_req(ACT_RELEASE, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        push_req(ACT_FIND,    1'b0, 16'h1234, 32'd19);   // hint invalid
        push_req(ACT_FIND,    1'b1, 16'h1234, 32'd20);
        push_req(ACT_LOAD,    1'b0, 16'hABCD, 32'hFFFF_FFFF);
        push_req(ACT_LOAD,    1'b1, 16'h5555, 32'd21);
        push_req(ACT_FIND,    1'b0, 16'h0000, 32'd22);   // slot 0 never matches a user
        push_req(ACT_UNUSED,  1'b1, 16'hFFFF, 32'hFFFF_FFFF);
        add_random(RANDOM_ITEMS);
        n_total = req_backlog.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (req_backlog.size() != 0 || in_valid || want_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (err_count == 0 && want_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/ustlru_pkg.sv
design/ustlru_ram.sv
design/user_slot_table_lru_top.sv
design/ustlru_checker.sv
sim/tb_top.sv
